// ----- src/dsp_pkg.sv -----
// Shared constants and types for the DAG shortest path engine.
package dsp_pkg;
    localparam int MaxVertices = 32;
    localparam int MaxEdges    = 256;
    localparam int VBits       = $clog2(MaxVertices);
    localparam int EBits       = $clog2(MaxEdges);
    localparam int WBits       = 16;
    localparam int DBits       = 21;

    localparam logic [1:0] KIND_STORED = 2'd0;
    localparam logic [1:0] KIND_FULL   = 2'd1;
    localparam logic [1:0] KIND_DIST   = 2'd2;

    typedef struct packed {
        logic [VBits-1:0]        tail;
        logic [VBits-1:0]        head;
        logic signed [WBits-1:0] weight;
    } t_edge;
endpackage

// ----- src/dsp_edge_mem.sv -----
// Edge table: one write port, one registered read port.
module dsp_edge_mem (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [dsp_pkg::EBits-1:0] i_waddr,
    input  dsp_pkg::t_edge           i_wdata,
    input  logic [dsp_pkg::EBits-1:0] i_raddr,
    output dsp_pkg::t_edge           o_rdata
);
    dsp_pkg::t_edge mem [dsp_pkg::MaxEdges];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule

// ----- src/dag_shortest_path_engine.sv -----
// Top level: edge loading, depth-first ordering, relaxation and result output.
//
//  channel | handshake         | payload                                   | dir
//  in      | i_valid, o_stall  | i_cmd i_edge_from i_edge_to i_edge_weight | in
//          |                   | i_source_vertex i_highest_vertex          |
//  out     | o_valid, i_stall  | o_kind o_vertex_index o_distance          | out
//          |                   | o_reachable o_last                        |
//
// An edge item is acknowledged through the output register. Each edge is read
// from the registered-read edge memory: address first, then data. A run performs
// ordering and relaxation, then emits n+1 results, one per free cycle.
// Input is stalled while a run is busy or a result waits. Reset is synchronous
// and clears the edge count and control state; the edge table is not cleared.
module dag_shortest_path_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_cmd,
    input  logic [4:0]  i_edge_from,
    input  logic [4:0]  i_edge_to,
    input  logic signed [15:0] i_edge_weight,
    input  logic [4:0]  i_source_vertex,
    input  logic [4:0]  i_highest_vertex,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_kind,
    output logic [4:0]  o_vertex_index,
    output logic signed [20:0] o_distance,
    output logic        o_reachable,
    output logic        o_last
);
    localparam int VB = dsp_pkg::VBits;
    localparam int EB = dsp_pkg::EBits;
    localparam int NV = dsp_pkg::MaxVertices;
    localparam int DB = dsp_pkg::DBits;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ROOT = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_RPICK = 3'd3;
    localparam logic [2:0] S_RSCAN = 3'd4;
    localparam logic [2:0] S_EMIT = 3'd5;

    logic [2:0]    r_state;
    logic [EB:0]   r_ecount;
    logic [VB-1:0] r_n, r_src, r_root, r_emit;
    logic [NV-1:0] r_visited, r_reached;
    logic [VB:0]   r_top, r_fin, r_fpos;
    logic [VB-1:0] r_svert [NV];
    logic [EB:0]   r_scur  [NV];
    logic [VB-1:0] r_forder [NV];
    logic signed [DB-1:0] r_dist [NV];
    logic [EB:0]   r_k;
    logic          r_rdv;
    logic [VB-1:0] r_u;

    logic          mem_we;
    logic [EB-1:0] mem_raddr;
    dsp_pkg::t_edge mem_wd;
    dsp_pkg::t_edge mem_rd;

    assign mem_wd = {i_edge_from, i_edge_to, i_edge_weight};

    dsp_edge_mem u_mem (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(r_ecount[EB-1:0]),
        .i_wdata(mem_wd),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rd)
    );

    logic in_acc, out_free, out_load;
    assign out_free = !o_valid || !i_stall;
    assign o_stall  = (r_state != S_IDLE) || !out_free;
    assign in_acc   = i_valid && !o_stall;
    assign mem_we   = in_acc && !i_cmd && (r_ecount < (EB+1)'(dsp_pkg::MaxEdges));
    assign out_load = (r_state == S_IDLE && in_acc && !i_cmd)
                   || (r_state == S_EMIT && out_free);

    logic [VB-1:0] top_v;
    logic [VB:0]   topm1;
    assign topm1 = r_top - 1'b1;
    assign top_v = r_svert[topm1[VB-1:0]];
    // cursor of active stack frame or relaxation index selects the read address
    always_comb begin
        if (r_state == S_RSCAN) mem_raddr = r_k[EB-1:0];
        else                    mem_raddr = r_scur[topm1[VB-1:0]][EB-1:0];
    end

    logic signed [DB+1:0] sum;
    logic signed [DB-1:0] sat;
    assign sum = (DB+2)'(r_dist[r_u]) + (DB+2)'(mem_rd.weight);
    always_comb begin
        if (sum > (DB+2)'(1048575))       sat = DB'(1048575);
        else if (sum < -(DB+2)'(1048576)) sat = -DB'(1048576);
        else                              sat = sum[DB-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ecount <= '0;
            o_valid  <= 1'b0;
            r_rdv    <= 1'b0;
        end else begin
            if (out_load) o_valid <= 1'b1;
            else if (!i_stall) o_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (!i_cmd) begin
                            o_kind  <= mem_we ? dsp_pkg::KIND_STORED : dsp_pkg::KIND_FULL;
                            o_vertex_index <= '0;
                            o_distance <= '0;
                            o_reachable <= 1'b0;
                            o_last <= 1'b1;
                            if (mem_we) r_ecount <= r_ecount + 1'b1;
                        end else begin
                            r_n <= i_highest_vertex;
                            r_src <= i_source_vertex;
                            r_visited <= '0;
                            r_reached <= '0;
                            r_root <= '0;
                            r_fin <= '0;
                            r_top <= '0;
                            r_state <= S_ROOT;
                        end
                    end
                end
                S_ROOT: begin
                    // push next unvisited root, or start relaxation
                    if (!r_visited[r_root]) begin
                        r_visited[r_root] <= 1'b1;
                        r_svert[0] <= r_root;
                        r_scur[0] <= '0;
                        r_top <= (VB+1)'(1);
                        r_rdv <= 1'b0;
                        r_state <= S_SCAN;
                    end else if (r_root == r_n) begin
                        r_fpos <= r_fin;
                        for (int i = 0; i < NV; i++) r_dist[i] <= '0;
                        if (r_src <= r_n) r_reached[r_src] <= 1'b1;
                        r_state <= S_RPICK;
                    end else begin
                        r_root <= r_root + 1'b1;
                    end
                end
                S_SCAN: begin
                    if (r_top == 0) begin
                        r_state <= S_ROOT;
                    end else if (r_scur[topm1[VB-1:0]] >= r_ecount) begin
                        r_forder[r_fin[VB-1:0]] <= top_v;
                        r_fin <= r_fin + 1'b1;
                        r_top <= topm1;
                        r_rdv <= 1'b0;
                    end else if (!r_rdv) begin
                        r_rdv <= 1'b1;  // wait for read data
                    end else begin
                        r_rdv <= 1'b0;
                        r_scur[topm1[VB-1:0]] <= r_scur[topm1[VB-1:0]] + 1'b1;
                        if (mem_rd.tail == top_v && mem_rd.head <= r_n
                                && !r_visited[mem_rd.head] && r_top < (VB+1)'(NV)) begin
                            r_visited[mem_rd.head] <= 1'b1;
                            r_svert[r_top[VB-1:0]] <= mem_rd.head;
                            r_scur[r_top[VB-1:0]] <= '0;
                            r_top <= r_top + 1'b1;
                        end
                    end
                end
                S_RPICK: begin
                    if (r_fpos == 0) begin
                        r_emit <= '0;
                        r_state <= S_EMIT;
                    end else begin
                        r_u <= r_forder[r_fpos[VB-1:0] - 1'b1];
                        r_fpos <= r_fpos - 1'b1;
                        if (r_reached[r_forder[r_fpos[VB-1:0] - 1'b1]]) begin
                            r_k <= '0;
                            r_rdv <= 1'b0;
                            r_state <= S_RSCAN;
                        end
                    end
                end
                S_RSCAN: begin
                    if (r_k >= r_ecount) begin
                        r_state <= S_RPICK;
                    end else if (!r_rdv) begin
                        r_rdv <= 1'b1;
                    end else begin
                        r_rdv <= 1'b0;
                        r_k <= r_k + 1'b1;
                        if (mem_rd.tail == r_u && mem_rd.head <= r_n
                                && (!r_reached[mem_rd.head] || sat < r_dist[mem_rd.head])) begin
                            r_dist[mem_rd.head] <= sat;
                            r_reached[mem_rd.head] <= 1'b1;
                        end
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        o_kind <= dsp_pkg::KIND_DIST;
                        o_vertex_index <= r_emit;
                        o_distance <= r_reached[r_emit] ? r_dist[r_emit] : '0;
                        o_reachable <= r_reached[r_emit];
                        o_last <= (r_emit == r_n);
                        if (r_emit == r_n) r_state <= S_IDLE;
                        else r_emit <= r_emit + 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
